### hdl/temh_pkg.sv
// Package for the timed-event min-heap: sizes, opcodes, status codes.
// No dependencies.
package temh_pkg;
  localparam int MaxEvents = 4096;
  localparam int SlotBits  = 12;
  localparam int IdBits    = 12;
  localparam int TimeBits  = 48;
  localparam int CountBits = 13;

  typedef logic [SlotBits-1:0]  slot_t;
  typedef logic [IdBits-1:0]    id_t;
  typedef logic [TimeBits-1:0]  tick_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [2:0]           status_t;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CHECK  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_FULL    = 3'd1;
  localparam status_t ST_BAD_ID  = 3'd2;
  localparam status_t ST_EMPTY   = 3'd3;
  localparam status_t ST_NOT_DUE = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    id_t        event_id;
    tick_t      time_value;
  } req_t;

  typedef struct packed {
    status_t status;
    id_t     popped_id;
    tick_t   lateness;
    logic    head_valid;
    id_t     head_id;
    tick_t   head_time;
    count_t  entry_count;
  } rsp_t;
endpackage

### hdl/temh_req_if.sv
// Valid/ready channel for requests.
// Depends on temh_pkg.
interface temh_req_if (input logic clk);
  import temh_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] opcode;
  id_t event_id;
  tick_t time_value;
  modport source (output valid, opcode, event_id, time_value, input ready);
  modport sink (input valid, opcode, event_id, time_value, output ready);
endinterface

### hdl/temh_rsp_if.sv
// Response channel.
// Depends on temh_pkg.
interface temh_rsp_if (input logic clk);
  import temh_pkg::*;
  logic valid;
  logic ready;
  status_t status;
  id_t popped_id;
  tick_t lateness;
  logic head_valid;
  id_t head_id;
  tick_t head_time;
  count_t entry_count;
  modport source (output valid, status, popped_id, lateness, head_valid, head_id,
                  head_time, entry_count, input ready);
  modport sink (input valid, status, popped_id, lateness, head_valid, head_id,
                head_time, entry_count, output ready);
endinterface

### hdl/temh_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module temh_ram #(
  parameter int Width = 8,
  parameter int AddrBits = 12
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AddrBits-1:0] addr,
  input  logic [Width-1:0]    wdata,
  output logic [Width-1:0]    rdata
);
  logic [Width-1:0] mem [2**AddrBits];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### hdl/timer_event_min_heap_core.sv
// Timed-event min-heap core. Depends on temh_pkg, temh_req_if, temh_rsp_if, temh_ram.
// Sequencer around single-port heap, slot and present RAMs and one shared comparator.
// A rejected or no-op request goes straight to the head read; insert sifts up;
// remove and a due check-due sift down, then up. Ready only in idle.
// Synchronous reset: occupancy zero, then a sweep over every event ID clears the present bits.
module timer_event_min_heap_core (
  input logic clk,
  input logic rst,
  temh_req_if.sink in_ch,
  temh_rsp_if.source out_ch
);
  import temh_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_CHKHEAD, S_INS,
    S_RM_SLOT, S_RM_LAST, S_RM_PUT, S_RM_PUT2,
    S_UP_LD, S_UP_RD, S_UP_CMP, S_DN_RDL, S_DN_RDR, S_DN_CMP, S_DN_RDP, S_DN_CHK,
    S_SW1, S_SW2, S_SW3, S_HEAD, S_HEAD2, S_OUT
  } state_t;

  state_t state;
  req_t req;
  rsp_t rsp;
  count_t occ;
  logic phase_down;
  slot_t cur, oth, rm_pos;
  id_t cur_id, oth_id;
  tick_t cur_t, oth_t, left_t;
  logic [SlotBits-1:0] clr_idx;

  // heap RAM (id,time), slot RAM, present RAM
  logic h_we; slot_t h_addr; logic [IdBits+TimeBits-1:0] h_wd, h_rd;
  logic s_we; id_t s_addr; slot_t s_wd, s_rd;
  logic p_we; id_t p_addr; logic p_wd, p_rd;

  temh_ram #(.Width(IdBits+TimeBits), .AddrBits(SlotBits)) u_heap (
    .clk, .we(h_we), .addr(h_addr), .wdata(h_wd), .rdata(h_rd));
  temh_ram #(.Width(SlotBits), .AddrBits(IdBits)) u_slot (
    .clk, .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));
  temh_ram #(.Width(1), .AddrBits(IdBits)) u_pres (
    .clk, .we(p_we), .addr(p_addr), .wdata(p_wd), .rdata(p_rd));

  id_t rd_id; tick_t rd_t;
  assign rd_id = h_rd[IdBits+TimeBits-1:TimeBits];
  assign rd_t = h_rd[TimeBits-1:0];

  // shared comparator: a >= b
  tick_t cmp_a, cmp_b; logic cmp_ge;
  assign cmp_ge = cmp_a >= cmp_b;

  count_t occ_m1;
  assign occ_m1 = occ - count_t'(1);
  logic [SlotBits:0] child_l;
  assign child_l = {cur, 1'b1};

  always_comb begin
    h_we = 1'b0; h_addr = cur; h_wd = {cur_id, cur_t};
    s_we = 1'b0; s_addr = req.event_id; s_wd = cur;
    p_we = 1'b0; p_addr = req.event_id; p_wd = 1'b0;
    cmp_a = oth_t; cmp_b = cur_t;
    unique case (state)
      S_CLEAR: begin p_we = 1'b1; p_addr = clr_idx; end
      S_IDLE: begin p_addr = in_ch.event_id; h_addr = '0; end
      S_DECODE: h_addr = '0;
      S_INS: begin
        h_we = 1'b1; h_addr = occ[SlotBits-1:0]; h_wd = {req.event_id, req.time_value};
        s_we = 1'b1; s_wd = occ[SlotBits-1:0]; p_we = 1'b1; p_wd = 1'b1;
      end
      S_CHKHEAD: begin cmp_a = req.time_value; cmp_b = rd_t; end
      S_RM_SLOT: begin p_we = 1'b1; h_addr = occ_m1[SlotBits-1:0]; end
      S_RM_LAST: h_addr = occ_m1[SlotBits-1:0];
      S_RM_PUT: begin
        h_we = 1'b1; s_we = 1'b1; s_addr = cur_id;
      end
      S_UP_RD: h_addr = (cur - slot_t'(1)) >> 1;
      S_UP_CMP: begin cmp_a = rd_t; cmp_b = cur_t; end
      // re-read the removed slot in case the down phase moved a child into it
      S_DN_CHK: h_addr = rm_pos;
      S_DN_RDL: h_addr = child_l[SlotBits-1:0];
      S_DN_RDR: h_addr = child_l[SlotBits-1:0] + slot_t'(1);
      S_DN_CMP: begin cmp_a = rd_t; cmp_b = left_t; end
      S_DN_RDP: begin h_addr = rm_pos; cmp_a = cur_t; cmp_b = oth_t; end
      S_SW1: begin h_we = 1'b1; h_addr = oth; h_wd = {cur_id, cur_t};
        s_we = 1'b1; s_addr = cur_id; s_wd = oth; end
      S_SW2: begin h_we = 1'b1; h_addr = cur; h_wd = {oth_id, oth_t};
        s_we = 1'b1; s_addr = oth_id; s_wd = cur; end
      S_HEAD: h_addr = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      occ <= '0;
      out_ch.valid <= 1'b0;
      in_ch.ready <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) begin state <= S_IDLE; in_ch.ready <= 1'b1; end
        end
        S_IDLE: if (in_ch.valid) begin
          req <= '{in_ch.opcode, in_ch.event_id, in_ch.time_value};
          rsp <= '0;
          in_ch.ready <= 1'b0;
          state <= S_DECODE;
        end
        S_DECODE: begin
          priority if (req.opcode == OP_INSERT) begin
            if (p_rd) begin rsp.status <= ST_BAD_ID; state <= S_HEAD; end
            else if (occ >= count_t'(MaxEvents)) begin
              rsp.status <= ST_FULL; state <= S_HEAD;
            end else state <= S_INS;
          end else if (req.opcode == OP_REMOVE) begin
            if (!p_rd || occ == '0) begin rsp.status <= ST_BAD_ID; state <= S_HEAD; end
            else begin rsp.popped_id <= req.event_id; state <= S_RM_SLOT; end
          end else if (req.opcode == OP_CHECK) begin
            if (occ == '0) begin rsp.status <= ST_EMPTY; state <= S_HEAD; end
            else state <= S_CHKHEAD;
          end else state <= S_HEAD;
        end
        S_CHKHEAD: begin
          if (!cmp_ge) begin rsp.status <= ST_NOT_DUE; state <= S_HEAD; end
          else begin
            rsp.lateness <= req.time_value - rd_t;
            rsp.popped_id <= rd_id;
            req.event_id <= rd_id;
            state <= S_RM_SLOT;
          end
        end
        S_INS: begin
          cur <= occ[SlotBits-1:0]; cur_id <= req.event_id; cur_t <= req.time_value;
          occ <= occ + 1'b1;
          phase_down <= 1'b0;
          state <= (occ == '0) ? S_HEAD : S_UP_RD;
        end
        S_RM_SLOT: state <= S_RM_LAST;
        S_RM_LAST: begin
          cur <= (count_t'(s_rd) >= occ) ? occ_m1[SlotBits-1:0] : s_rd;
          cur_id <= rd_id; cur_t <= rd_t;
          occ <= occ_m1;
          if (count_t'(s_rd) >= occ_m1) state <= S_HEAD;
          else state <= S_RM_PUT;
        end
        S_RM_PUT: begin phase_down <= 1'b1; rm_pos <= cur; state <= S_DN_CHK; end
        S_DN_CHK: begin
          if (count_t'(child_l) < occ) state <= S_DN_RDL;
          else begin phase_down <= 1'b0; state <= S_UP_LD; end
        end
        S_DN_RDL: state <= S_DN_RDR;
        S_DN_RDR: begin
          left_t <= rd_t; oth_id <= rd_id; oth_t <= rd_t;
          oth <= child_l[SlotBits-1:0];
          state <= (count_t'(child_l) + 1'b1 < occ) ? S_DN_CMP : S_DN_RDP;
        end
        S_DN_CMP: begin
          // right child only when the left one is strictly later
          if (!cmp_ge) begin
            oth <= child_l[SlotBits-1:0] + slot_t'(1); oth_id <= rd_id; oth_t <= rd_t;
          end
          state <= S_DN_RDP;
        end
        S_DN_RDP: begin
          // parent cur swaps with child oth when cur_t >= oth_t
          if (!cmp_ge) begin
            phase_down <= 1'b0; state <= S_UP_LD;
          end else state <= S_SW1;
        end
        // up phase restarts at the removed slot with whatever it now holds
        S_UP_LD: begin
          cur <= rm_pos; cur_id <= rd_id; cur_t <= rd_t;
          state <= S_UP_RD;
        end
        S_UP_RD: begin
          if (cur == '0) state <= S_HEAD;
          else begin oth <= (cur - slot_t'(1)) >> 1; state <= S_UP_CMP; end
        end
        S_UP_CMP: begin
          oth_id <= rd_id; oth_t <= rd_t;
          if (cmp_ge) state <= S_SW1; else state <= S_HEAD;
        end
        S_SW1: state <= S_SW2;
        S_SW2: begin cur <= oth; state <= S_SW3; end
        S_SW3: state <= phase_down ? S_DN_CHK : S_UP_RD;
        S_HEAD: state <= S_HEAD2;
        S_HEAD2: begin
          rsp.head_valid <= occ != '0;
          rsp.head_id <= (occ != '0) ? rd_id : '0;
          rsp.head_time <= (occ != '0) ? rd_t : '0;
          rsp.entry_count <= occ;
          out_ch.valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          out_ch.valid <= 1'b0; in_ch.ready <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.status = rsp.status;
  assign out_ch.popped_id = rsp.popped_id;
  assign out_ch.lateness = rsp.lateness;
  assign out_ch.head_valid = rsp.head_valid;
  assign out_ch.head_id = rsp.head_id;
  assign out_ch.head_time = rsp.head_time;
  assign out_ch.entry_count = rsp.entry_count;
endmodule
